### design/alignment_column_consensus_macros.svh
// Assertion macros shared by the alignment column consensus design.
// Depends on nothing; included by the controller and the datapath.
`ifndef ALIGNMENT_COLUMN_CONSENSUS_MACROS_SVH
`define ALIGNMENT_COLUMN_CONSENSUS_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, switched off while reset is asserted.
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acc: implication check failed");
// Next-cycle implication, switched off while reset is asserted.
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acc: next-cycle check failed");
`else
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/acc_pkg.sv
// Shared constants, types and helpers of the alignment column consensus block.
// Depends on nothing; imported by every module of the design except acc_ram.
package acc_pkg;

    // Sizing of the column store and of the per-column counters.
    localparam int MAX_COLUMNS   = 4096;
    localparam int MAX_SEQUENCES = 1024;
    localparam int COL_AW        = $clog2(MAX_COLUMNS);
    localparam int COL_CW        = COL_AW + 1;
    localparam int SEQ_CW        = $clog2(MAX_SEQUENCES) + 1;
    localparam int NUM_COUNTS    = 5;
    localparam int CODE_W        = 3;

    // Residue class codes; the first five index the counters.
    typedef logic [CODE_W-1:0] t_code;
    localparam t_code CODE_A     = 3'd0;
    localparam t_code CODE_C     = 3'd1;
    localparam t_code CODE_G     = 3'd2;
    localparam t_code CODE_T     = 3'd3;
    localparam t_code CODE_GAP   = 3'd4;
    localparam t_code CODE_OTHER = 3'd5;

    // Input item kinds and result kinds.
    localparam logic KIND_RESIDUE  = 1'b0;
    localparam logic KIND_FETCH    = 1'b1;
    localparam logic RKIND_SUMMARY = 1'b0;
    localparam logic RKIND_LETTER  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_residue;
        logic end_col;
        logic summary;
        logic emit_sum;
        logic emit_empty;
        logic rd_req;
        logic scan_skip;
        logic emit_letter;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fetch_ok;
        logic out_free;
        logic rd_gap;
    } t_dp_sts;

    // Case-insensitive classification of one ASCII residue.
    function automatic t_code classify(input logic [7:0] ch);
        logic [7:0] up;
        t_code      code;
        up = ((ch >= 8'h61) && (ch <= 8'h7A)) ? (ch - 8'd32) : ch;
        case (up)
            8'h41: code = CODE_A;
            8'h43: code = CODE_C;
            8'h47: code = CODE_G;
            8'h54: code = CODE_T;
            8'h2D: code = CODE_GAP;
            default: code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

### design/alignment_column_consensus.sv
// Alignment column consensus: a residue beat is taken in S_IDLE, a column end
// adds S_ENDCOL, and the last column adds S_SUMMARY before the summary is emitted.
// A fetch that finds a letter passes S_RD and S_CHK, again for each gap column
// skipped in the registered-read column store; an empty fetch goes to S_EMIT_EMPTY.
// One item is worked on at a time, and a result waiting for the output holds it.
// Synchronous active-low reset clears all control state and exact_mode to 0.
module alignment_column_consensus (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_kind,
    input  logic [7:0]                i_residue,
    input  logic                      i_last_in_column,
    input  logic                      i_last_column,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_result_kind,
    output logic [1:0]                o_letter,
    output logic                      o_letter_valid,
    output logic                      o_last_letter,
    output logic [acc_pkg::COL_CW-1:0] o_consensus_length,
    output logic [acc_pkg::COL_AW-1:0] o_window_start,
    output logic [acc_pkg::COL_AW-1:0] o_window_end,
    output logic                      o_overflow
);
    import acc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    acc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_kind           (i_kind),
        .i_last_in_column (i_last_in_column),
        .i_last_column    (i_last_column),
        .i_sts            (sts),
        .o_cmd            (cmd),
        .o_in_stall       (o_in_stall)
    );

    // Counters, column store and output register.
    acc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .o_cfg_ready        (o_cfg_ready),
        .i_residue          (i_residue),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_result_kind      (o_result_kind),
        .o_letter           (o_letter),
        .o_letter_valid     (o_letter_valid),
        .o_last_letter      (o_last_letter),
        .o_consensus_length (o_consensus_length),
        .o_window_start     (o_window_start),
        .o_window_end       (o_window_end),
        .o_overflow         (o_overflow)
    );

endmodule

### design/acc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the column store.
module acc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/acc_ctrl.sv
// Controller state machine of the alignment column consensus block.
// Depends on acc_pkg and on alignment_column_consensus_macros.svh.
`include "alignment_column_consensus_macros.svh"

module acc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    input  logic            i_last_in_column,
    input  logic            i_last_column,
    input  acc_pkg::t_dp_sts i_sts,
    output acc_pkg::t_dp_cmd o_cmd,
    output logic            o_in_stall
);
    import acc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_ENDCOL     = 7'b0000010,
        S_SUMMARY    = 7'b0000100,
        S_EMIT_SUM   = 7'b0001000,
        S_EMIT_EMPTY = 7'b0010000,
        S_RD         = 7'b0100000,
        S_CHK        = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_eoa, n_eoa;
    t_dp_cmd cmd;

    // Next state and command decode.
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_eoa   = r_eoa;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_FETCH) begin
                        n_state = i_sts.fetch_ok ? S_RD : S_EMIT_EMPTY;
                    end else begin
                        cmd.acc_residue = 1'b1;
                        if (i_last_in_column) begin
                            n_eoa   = i_last_column;
                            n_state = S_ENDCOL;
                        end
                    end
                end
            end
            S_ENDCOL: begin
                cmd.end_col = 1'b1;
                n_state     = r_eoa ? S_SUMMARY : S_IDLE;
            end
            S_SUMMARY: begin
                cmd.summary = 1'b1;
                n_state     = S_EMIT_SUM;
            end
            S_EMIT_SUM: begin
                if (i_sts.out_free) begin
                    cmd.emit_sum = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT_EMPTY: begin
                if (i_sts.out_free) begin
                    cmd.emit_empty = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RD: begin
                cmd.rd_req = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                // Gap columns are skipped; a letter waits for the output register.
                if (i_sts.rd_gap) begin
                    cmd.scan_skip = 1'b1;
                    n_state       = S_RD;
                end else if (i_sts.out_free) begin
                    cmd.emit_letter = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eoa   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eoa   <= n_eoa;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    // A summary that finds the output register occupied waits for it.
    `ACC_ASSERT_NEXT(a_sum_waits, i_clk, i_rst_n, (r_state == S_EMIT_SUM) && !i_sts.out_free, r_state == S_EMIT_SUM)

endmodule

### design/acc_datapath.sv
// Datapath of the alignment column consensus block: counters, run tracking,
// column store, readout scan and output register. Depends on acc_pkg, acc_ram
// and alignment_column_consensus_macros.svh.
`include "alignment_column_consensus_macros.svh"

module acc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_data,
    output logic                      o_cfg_ready,
    input  logic [7:0]                i_residue,
    input  acc_pkg::t_dp_cmd          i_cmd,
    output acc_pkg::t_dp_sts          o_sts,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_result_kind,
    output logic [1:0]                o_letter,
    output logic                      o_letter_valid,
    output logic                      o_last_letter,
    output logic [acc_pkg::COL_CW-1:0] o_consensus_length,
    output logic [acc_pkg::COL_AW-1:0] o_window_start,
    output logic [acc_pkg::COL_AW-1:0] o_window_end,
    output logic                      o_overflow
);
    import acc_pkg::*;

    // Configuration and alignment state.
    logic              r_exact;
    logic [SEQ_CW-1:0] r_cnt [NUM_COUNTS];
    logic [SEQ_CW-1:0] n_cnt [NUM_COUNTS];
    logic [SEQ_CW-1:0] r_col_size, n_col_size;
    logic [COL_CW-1:0] r_col_idx, n_col_idx;
    logic [COL_AW-1:0] r_run_start, n_run_start;
    logic [COL_CW-1:0] r_run_len, n_run_len;
    logic [COL_AW-1:0] r_best_start, n_best_start;
    logic [COL_AW-1:0] r_best_end, n_best_end;
    logic [COL_CW-1:0] r_best_len, n_best_len;
    logic [COL_CW-1:0] r_nongap, n_nongap;
    logic              r_col0_gap, n_col0_gap;
    logic [COL_CW-1:0] r_kept, n_kept;
    logic [COL_CW-1:0] r_rd_ptr, n_rd_ptr;
    logic [COL_CW-1:0] r_scan, n_scan;
    logic              r_overflow, n_overflow;
    logic              r_finished, n_finished;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic              r_o_kind, n_o_kind;
    logic [1:0]        r_o_letter, n_o_letter;
    logic              r_o_lvalid, n_o_lvalid;
    logic              r_o_last, n_o_last;
    logic [COL_CW-1:0] r_o_len, n_o_len;
    logic [COL_AW-1:0] r_o_ws, n_o_ws;
    logic [COL_AW-1:0] r_o_we, n_o_we;
    logic              r_o_ovf, n_o_ovf;

    t_code             res_code;
    t_code             major;
    logic [SEQ_CW-1:0] top;
    logic              conserved;
    logic              col_store;
    logic [COL_CW-1:0] run_end_full;
    logic [COL_CW-1:0] last_col_full;
    logic [COL_CW-1:0] cl_len;
    logic [COL_AW-1:0] cl_start;
    logic [COL_AW-1:0] cl_end;
    logic [COL_CW-1:0] rp_inc;
    logic [CODE_W-1:0] ram_rdata;
    logic              out_free;

    assign res_code  = classify(i_residue);
    assign col_store = (r_col_idx < COL_CW'(MAX_COLUMNS));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rp_inc    = r_rd_ptr + 1'b1;

    // Majority code of the finished column; ties keep the earlier code.
    always_comb begin
        major = CODE_A;
        top   = '0;
        for (int i = 0; i < NUM_COUNTS; i++) begin
            if (r_cnt[i] > top) begin
                top   = r_cnt[i];
                major = t_code'(i);
            end
        end
    end

    // A column is conserved when it has no gap and one letter fills it or none is in it.
    always_comb begin
        conserved = (r_cnt[CODE_GAP] == '0);
        for (int i = 0; i < 4; i++) begin
            if ((r_cnt[i] != '0) && (r_cnt[i] != r_col_size)) begin
                conserved = 1'b0;
            end
        end
    end

    // Last column of the current run and of the stored alignment.
    assign run_end_full  = {1'b0, r_run_start} + r_run_len - 1'b1;
    assign last_col_full = r_col_idx - 1'b1;

    // Best run after closing the current one.
    always_comb begin
        if (r_run_len > r_best_len) begin
            cl_len   = r_run_len;
            cl_start = r_run_start;
            cl_end   = run_end_full[COL_AW-1:0];
        end else begin
            cl_len   = r_best_len;
            cl_start = r_best_start;
            cl_end   = r_best_end;
        end
    end

    // Next values of the alignment state.
    always_comb begin
        n_cnt        = r_cnt;
        n_col_size   = r_col_size;
        n_col_idx    = r_col_idx;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        n_best_len   = r_best_len;
        n_nongap     = r_nongap;
        n_col0_gap   = r_col0_gap;
        n_kept       = r_kept;
        n_rd_ptr     = r_rd_ptr;
        n_scan       = r_scan;
        n_overflow   = r_overflow;
        n_finished   = r_finished;

        // Residue beat: a new alignment clears everything first.
        if (i_cmd.acc_residue) begin
            if (r_finished) begin
                for (int i = 0; i < NUM_COUNTS; i++) begin
                    n_cnt[i] = '0;
                end
                n_col_size   = '0;
                n_col_idx    = '0;
                n_run_start  = '0;
                n_run_len    = '0;
                n_best_start = '0;
                n_best_end   = '0;
                n_best_len   = '0;
                n_nongap     = '0;
                n_col0_gap   = 1'b0;
                n_kept       = '0;
                n_rd_ptr     = '0;
                n_scan       = '0;
                n_overflow   = 1'b0;
                n_finished   = 1'b0;
            end
            if (n_col_size < SEQ_CW'(MAX_SEQUENCES)) begin
                if (res_code != CODE_OTHER) begin
                    n_cnt[res_code] = n_cnt[res_code] + 1'b1;
                end
                n_col_size = n_col_size + 1'b1;
            end
        end

        // Column end: store the majority and track conserved runs.
        if (i_cmd.end_col) begin
            if (col_store) begin
                if (major != CODE_GAP) begin
                    n_nongap = r_nongap + 1'b1;
                end
                if (r_col_idx == '0) begin
                    n_col0_gap = (major == CODE_GAP);
                end
                if (conserved) begin
                    if (r_run_len == '0) begin
                        n_run_start = r_col_idx[COL_AW-1:0];
                    end
                    n_run_len = r_run_len + 1'b1;
                end else begin
                    n_best_len   = cl_len;
                    n_best_start = cl_start;
                    n_best_end   = cl_end;
                    n_run_len    = '0;
                end
                n_col_idx = r_col_idx + 1'b1;
            end else begin
                n_overflow = 1'b1;
            end
            for (int i = 0; i < NUM_COUNTS; i++) begin
                n_cnt[i] = '0;
            end
            n_col_size = '0;
        end

        // Alignment end: settle the window and the number of letters.
        if (i_cmd.summary) begin
            n_run_len  = '0;
            n_best_len = cl_len;
            if (r_exact) begin
                n_best_start = cl_start;
                n_best_end   = cl_end;
                n_scan       = {1'b0, cl_start};
                if (cl_len != '0) begin
                    n_kept = cl_len;
                end else begin
                    n_kept = r_col0_gap ? '0 : COL_CW'(1);
                end
            end else begin
                n_best_start = '0;
                n_best_end   = last_col_full[COL_AW-1:0];
                n_scan       = '0;
                n_kept       = r_nongap;
            end
            n_rd_ptr   = '0;
            n_finished = 1'b1;
        end

        // Readout scan over the window.
        if (i_cmd.scan_skip) begin
            n_scan = r_scan + 1'b1;
        end
        if (i_cmd.emit_letter) begin
            n_scan   = r_scan + 1'b1;
            n_rd_ptr = rp_inc;
        end
    end

    // Next values of the output register.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_o_kind    = r_o_kind;
        n_o_letter  = r_o_letter;
        n_o_lvalid  = r_o_lvalid;
        n_o_last    = r_o_last;
        n_o_len     = r_o_len;
        n_o_ws      = r_o_ws;
        n_o_we      = r_o_we;
        n_o_ovf     = r_o_ovf;
        if (i_cmd.emit_sum || i_cmd.emit_empty || i_cmd.emit_letter) begin
            n_out_valid = 1'b1;
            n_o_kind    = RKIND_LETTER;
            n_o_letter  = '0;
            n_o_lvalid  = 1'b0;
            n_o_last    = 1'b0;
            n_o_len     = '0;
            n_o_ws      = '0;
            n_o_we      = '0;
            n_o_ovf     = 1'b0;
            if (i_cmd.emit_sum) begin
                n_o_kind = RKIND_SUMMARY;
                n_o_len  = r_kept;
                n_o_ws   = r_best_start;
                n_o_we   = r_best_end;
                n_o_ovf  = r_overflow;
            end
            if (i_cmd.emit_letter) begin
                n_o_letter = ram_rdata[1:0];
                n_o_lvalid = 1'b1;
                n_o_last   = (rp_inc == r_kept);
            end
        end
    end

    // Control and alignment registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact      <= 1'b0;
            for (int i = 0; i < NUM_COUNTS; i++) begin
                r_cnt[i] <= '0;
            end
            r_col_size   <= '0;
            r_col_idx    <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_best_len   <= '0;
            r_nongap     <= '0;
            r_col0_gap   <= 1'b0;
            r_kept       <= '0;
            r_rd_ptr     <= '0;
            r_scan       <= '0;
            r_overflow   <= 1'b0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_exact <= i_cfg_data;
            end
            r_cnt        <= n_cnt;
            r_col_size   <= n_col_size;
            r_col_idx    <= n_col_idx;
            r_run_start  <= n_run_start;
            r_run_len    <= n_run_len;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
            r_best_len   <= n_best_len;
            r_nongap     <= n_nongap;
            r_col0_gap   <= n_col0_gap;
            r_kept       <= n_kept;
            r_rd_ptr     <= n_rd_ptr;
            r_scan       <= n_scan;
            r_overflow   <= n_overflow;
            r_finished   <= n_finished;
            r_out_valid  <= n_out_valid;
        end
    end

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        r_o_kind   <= n_o_kind;
        r_o_letter <= n_o_letter;
        r_o_lvalid <= n_o_lvalid;
        r_o_last   <= n_o_last;
        r_o_len    <= n_o_len;
        r_o_ws     <= n_o_ws;
        r_o_we     <= n_o_we;
        r_o_ovf    <= n_o_ovf;
    end

    // Column store: one majority code per stored column.
    acc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.end_col && col_store),
        .i_waddr (r_col_idx[COL_AW-1:0]),
        .i_wdata (major),
        .i_re    (i_cmd.rd_req),
        .i_raddr (r_scan[COL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_sts.fetch_ok = r_finished && (r_rd_ptr < r_kept);
    assign o_sts.out_free = out_free;
    assign o_sts.rd_gap   = (ram_rdata == CODE_GAP);

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_o_kind;
    assign o_letter           = r_o_letter;
    assign o_letter_valid     = r_o_lvalid;
    assign o_last_letter      = r_o_last;
    assign o_consensus_length = r_o_len;
    assign o_window_start     = r_o_ws;
    assign o_window_end       = r_o_we;
    assign o_overflow         = r_o_ovf;

    // A letter is only read out while letters remain.
    `ACC_ASSERT_IMP(a_letter_left, i_clk, i_rst_n, i_cmd.emit_letter, r_rd_ptr < r_kept)
    // The readout scan never reads past the end of the window.
    `ACC_ASSERT_IMP(a_scan_in_window, i_clk, i_rst_n, i_cmd.rd_req, r_scan <= {1'b0, r_best_end})
    // A finished alignment never promises more letters than stored columns.
    `ACC_ASSERT_IMP(a_kept_bound, i_clk, i_rst_n, r_finished, r_kept <= r_col_idx)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the alignment column consensus block.
// Depends on acc_pkg and the alignment_column_consensus top level only.
module tb;
    import acc_pkg::*;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SHOW_LIMIT    = 10;
    localparam int          PHASE_BEATS   = 30;
    localparam logic [7:0]  ASC_A         = "A";
    localparam logic [7:0]  ASC_C         = "C";
    localparam logic [7:0]  ASC_G         = "G";
    localparam logic [7:0]  ASC_T         = "T";
    localparam logic [7:0]  ASC_GAP       = "-";
    localparam logic [7:0]  ASC_LC_A      = "a";
    localparam logic [7:0]  ASC_LC_Z      = "z";
    localparam logic [7:0]  CASE_BIT      = 8'h20;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} t_stall_style;

    // One input beat as queued for the driver.
    typedef struct {
        logic       kind;
        logic [7:0] ch;
        logic       eoc;
        logic       eoa;
        logic       hold;
    } t_alignment_beat;

    // One result beat: a summary or a consensus letter.
    typedef struct packed {
        logic              rkind;
        logic [1:0]        letter;
        logic              lvalid;
        logic              is_last;
        logic [COL_CW-1:0] cons_len;
        logic [COL_AW-1:0] win_start;
        logic [COL_AW-1:0] win_end;
        logic              ovf;
    } t_consensus_beat;

    // Ports of the block.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = 1'b0;
    logic [7:0]        i_residue = 8'h00;
    logic              i_last_in_column = 1'b0;
    logic              i_last_column = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_result_kind;
    logic [1:0]        o_letter;
    logic              o_letter_valid;
    logic              o_last_letter;
    logic [COL_CW-1:0] o_consensus_length;
    logic [COL_AW-1:0] o_window_start;
    logic [COL_AW-1:0] o_window_end;
    logic              o_overflow;

    alignment_column_consensus DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_residue          (i_residue),
        .i_last_in_column   (i_last_in_column),
        .i_last_column      (i_last_column),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_letter           (o_letter),
        .o_letter_valid     (o_letter_valid),
        .o_last_letter      (o_last_letter),
        .o_consensus_length (o_consensus_length),
        .o_window_start     (o_window_start),
        .o_window_end       (o_window_end),
        .o_overflow         (o_overflow)
    );

    // Clock: 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the block's alignment state.
    logic        exact_sel = 1'b0;
    int unsigned base_tally [NUM_COUNTS] = '{default: 0};
    int unsigned col_depth = 0;
    int unsigned col_count = 0;
    int unsigned run_first = 0;
    int unsigned run_len = 0;
    int unsigned win_first = 0;
    int unsigned win_last = 0;
    int unsigned win_len = 0;
    t_code       col_major [MAX_COLUMNS] = '{default: CODE_A};
    int unsigned letters_sent = 0;
    int unsigned letters_total = 0;
    logic        cols_dropped = 1'b0;
    logic        aln_closed = 1'b0;

    // Stimulus, scoreboard and bookkeeping.
    t_alignment_beat pending_beats [$];
    t_alignment_beat next_beat;
    t_consensus_beat consensus_due [$];
    t_consensus_beat got_beat;
    t_consensus_beat want_beat;
    int              beats_queued = 0;
    int              beats_in = 0;
    int              results_checked = 0;
    int              letters_seen = 0;
    int              summaries_seen = 0;
    int              fault_count = 0;
    int unsigned     cycle_count = 0;
    int              gap_left = 0;
    int              burst_left = 1;
    int              hold_left = 0;
    int              seg_left = 0;
    t_stall_style    stall_style = STALL_NONE;
    logic            cur_hold = 1'b0;
    logic            in_taken = 1'b0;

    wire in_fire = i_rst_n && i_in_valid && !o_in_stall;

    // A conserved run has ended: keep it if it is the longest so far.
    function automatic void close_conserved_run();
        if (run_len > win_len) begin
            win_len   = run_len;
            win_first = run_first;
            win_last  = run_first + run_len - 1;
        end
        run_len = 0;
    endfunction

    // Resolve the majority of the current column and track conserved runs.
    function automatic void finish_column();
        int unsigned top;
        int          i;
        t_code       major;
        logic        cons;
        if (col_count < MAX_COLUMNS) begin
            major = CODE_A;
            top   = 0;
            cons  = (base_tally[CODE_GAP] == 0);
            for (i = 0; i < NUM_COUNTS; i++) begin
                if (base_tally[i] > top) begin
                    top   = base_tally[i];
                    major = t_code'(i);
                end
            end
            for (i = 0; i < 4; i++) begin
                if (base_tally[i] != 0 && base_tally[i] != col_depth)
                    cons = 1'b0;
            end
            col_major[col_count] = major;
            if (cons) begin
                if (run_len == 0)
                    run_first = col_count;
                run_len++;
            end else begin
                close_conserved_run();
            end
            col_count++;
        end else begin
            cols_dropped = 1'b1;
        end
        base_tally = '{default: 0};
        col_depth  = 0;
    endfunction

    // Work out the result, if any, of one accepted input beat.
    function automatic void compute_consensus_beat(input logic kind, input logic [7:0] ch,
                                                   input logic eoc, input logic eoa);
        t_consensus_beat r;
        logic [7:0]      up;
        int unsigned     c;
        int unsigned     seen;
        r = '0;
        if (kind == KIND_FETCH) begin
            r.rkind = RKIND_LETTER;
            if (aln_closed && letters_sent < letters_total) begin
                seen = 0;
                for (c = win_first; c <= win_last && c < MAX_COLUMNS; c++) begin
                    if (col_major[c] == CODE_GAP)
                        continue;
                    if (seen == letters_sent) begin
                        r.letter  = col_major[c][1:0];
                        r.lvalid  = 1'b1;
                        letters_sent++;
                        r.is_last = (letters_sent == letters_total);
                        break;
                    end
                    seen++;
                end
            end
            consensus_due.push_back(r);
            return;
        end

        // A residue after the summary opens a fresh alignment.
        if (aln_closed) begin
            base_tally    = '{default: 0};
            col_depth     = 0;
            col_count     = 0;
            run_first     = 0;
            run_len       = 0;
            win_first     = 0;
            win_last      = 0;
            win_len       = 0;
            letters_sent  = 0;
            letters_total = 0;
            cols_dropped  = 1'b0;
            aln_closed    = 1'b0;
        end

        // Residues past the column depth limit are not counted.
        if (col_depth < MAX_SEQUENCES) begin
            up = (ch >= ASC_LC_A && ch <= ASC_LC_Z) ? (ch - CASE_BIT) : ch;
            case (up)
                ASC_A:   base_tally[CODE_A]++;
                ASC_C:   base_tally[CODE_C]++;
                ASC_G:   base_tally[CODE_G]++;
                ASC_T:   base_tally[CODE_T]++;
                ASC_GAP: base_tally[CODE_GAP]++;
                default: ;
            endcase
            col_depth++;
        end

        if (!eoc)
            return;
        finish_column();
        if (!eoa)
            return;

        // Final column: fix the window and count the letters it keeps.
        close_conserved_run();
        if (!exact_sel) begin
            win_first = 0;
            win_last  = col_count - 1;
        end
        letters_total = 0;
        for (c = win_first; c <= win_last && c < MAX_COLUMNS; c++) begin
            if (col_major[c] != CODE_GAP)
                letters_total++;
        end
        aln_closed   = 1'b1;
        letters_sent = 0;
        r.rkind      = RKIND_SUMMARY;
        r.cons_len   = letters_total[COL_CW-1:0];
        r.win_start  = win_first[COL_AW-1:0];
        r.win_end    = win_last[COL_AW-1:0];
        r.ovf        = cols_dropped;
        consensus_due.push_back(r);
    endfunction

    function automatic string describe(input t_consensus_beat b);
        return $sformatf("kind %0d letter %0d valid %0d last %0d len %0d start %0d end %0d ovf %0d",
                         b.rkind, b.letter, b.lvalid, b.is_last, b.cons_len, b.win_start,
                         b.win_end, b.ovf);
    endfunction

    // Input driver: bursts of beats with random gaps, payload held while stalled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_beats.size() != 0) begin
                next_beat = pending_beats.pop_front();
                i_in_valid       <= 1'b1;
                i_kind           <= next_beat.kind;
                i_residue        <= next_beat.ch;
                i_last_in_column <= next_beat.eoc;
                i_last_column    <= next_beat.eoa;
                cur_hold         <= next_beat.hold;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                              : $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long hold-off of the result side, started by a marked beat.
    always @(posedge i_clk) begin
        if (in_fire && cur_hold)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result-side stall: segments of differing stall density.
    always @(negedge i_clk) begin : receiver_pattern
        logic busy_now;
        case (stall_style)
            STALL_NONE:  busy_now = 1'b0;
            STALL_LIGHT: busy_now = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: busy_now = ($urandom_range(0, 3) != 0);
            default:     busy_now = (seg_left % 2 == 1);
        endcase
        if (seg_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            seg_left    <= $urandom_range(10, 120);
        end else begin
            seg_left <= seg_left - 1;
        end
        i_out_stall <= i_rst_n && ((hold_left != 0) || busy_now);
    end

    // Monitor: predict on each accepted input beat, check each accepted result.
    always @(posedge i_clk) begin
        in_taken <= in_fire;
        if (i_rst_n) begin
            if (in_fire) begin
                compute_consensus_beat(i_kind, i_residue, i_last_in_column, i_last_column);
                beats_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                got_beat.rkind     = o_result_kind;
                got_beat.letter    = o_letter;
                got_beat.lvalid    = o_letter_valid;
                got_beat.is_last   = o_last_letter;
                got_beat.cons_len  = o_consensus_length;
                got_beat.win_start = o_window_start;
                got_beat.win_end   = o_window_end;
                got_beat.ovf       = o_overflow;
                if (consensus_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display("%0t: result with none outstanding: %s", $time,
                                 describe(got_beat));
                end else begin
                    want_beat = consensus_due.pop_front();
                    results_checked++;
                    if (got_beat !== want_beat) begin
                        fault_count++;
                        if (fault_count <= SHOW_LIMIT) begin
                            $display("%0t: result %0d differs", $time, results_checked);
                            $display("    expected %s", describe(want_beat));
                            $display("    actual   %s", describe(got_beat));
                        end
                    end
                    if (want_beat.rkind == RKIND_SUMMARY)
                        summaries_seen++;
                    else if (want_beat.lvalid)
                        letters_seen++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, consensus_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus building.
    task automatic add_beat(input logic kind, input logic [7:0] ch, input logic eoc,
                            input logic eoa, input logic hold);
        t_alignment_beat b;
        b.kind = kind;
        b.ch   = ch;
        b.eoc  = eoc;
        b.eoa  = eoa;
        b.hold = hold;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [7:0] residue_for(input t_code code);
        logic [7:0] up;
        case (code)
            CODE_A:   up = ASC_A;
            CODE_C:   up = ASC_C;
            CODE_G:   up = ASC_G;
            CODE_T:   up = ASC_T;
            CODE_GAP: up = ASC_GAP;
            default:  up = 8'($urandom_range(0, 255));
        endcase
        if (code < CODE_GAP && $urandom_range(0, 1) == 1)
            up = up | CASE_BIT;
        return up;
    endfunction

    // One column: conserved, noisy, gap-heavy or fully random.
    task automatic add_column(input int nseq, input logic closes);
        t_code base;
        t_code code;
        int    s;
        int    style;
        style = $urandom_range(0, 9);
        base  = t_code'($urandom_range(0, 3));
        for (s = 0; s < nseq; s++) begin
            if (style < 5)
                code = base;
            else if (style < 7)
                code = ($urandom_range(0, 3) == 0) ? t_code'($urandom_range(0, 5)) : base;
            else if (style == 7)
                code = ($urandom_range(0, 3) == 0) ? t_code'($urandom_range(0, 5)) : CODE_GAP;
            else
                code = t_code'($urandom_range(0, 5));
            add_beat(KIND_RESIDUE, residue_for(code), s == nseq - 1,
                     closes && (s == nseq - 1), 1'b0);
        end
    endtask

    task automatic add_alignment(input int ncol, input int nseq, input logic closes);
        int c;
        for (c = 0; c < ncol; c++)
            add_column(($urandom_range(0, 7) == 0) ? $urandom_range(1, nseq + 2) : nseq,
                       closes && (c == ncol - 1));
    endtask

    task automatic add_fetches(input int n, input logic hold);
        int k;
        for (k = 0; k < n; k++)
            add_beat(KIND_FETCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), hold && (k == 0));
    endtask

    // Mostly whole alignments with readout; some noise and cut-off alignments.
    task automatic add_random_phase(input int target, input logic with_hold);
        int start_n;
        int ncol;
        int nseq;
        int pick;
        start_n = beats_queued;
        while (beats_queued - start_n < target) begin
            pick = $urandom_range(0, 99);
            ncol = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            nseq = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            if (pick < 80) begin
                add_alignment(ncol, nseq, 1'b1);
                if ($urandom_range(0, 9) < 7)
                    add_fetches(ncol + $urandom_range(0, 2), 1'b0);
                else
                    add_fetches($urandom_range(0, ncol), 1'b0);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6))
                    add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
            end else begin
                add_alignment(ncol, nseq, 1'b0);
                add_fetches(1, 1'b0);
            end
            // Halfway through, hold the results back while letters are fetched.
            if (with_hold && beats_queued - start_n >= target / 2) begin
                add_alignment(20, 3, 1'b1);
                add_fetches(30, 1'b1);
                with_hold = 1'b0;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || i_in_valid || consensus_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_exact_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_data  <= mode;
        i_cfg_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        exact_sel = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int p;
        int k;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_exact_mode(1'b0);

        // Directed: fetch before any summary, ties, gap majority, lower case,
        // a stray final-column mark and a column of other bytes.
        add_fetches(1, 1'b0);
        add_beat(KIND_RESIDUE, ASC_A | CASE_BIT, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_A, 1'b1, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_GAP, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_GAP, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_C, 1'b1, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_C, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_G | CASE_BIT, 1'b1, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, 8'hFF, 1'b0, 1'b1, 1'b0);
        add_beat(KIND_RESIDUE, 8'h00, 1'b1, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_T | CASE_BIT, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_T, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_T | CASE_BIT, 1'b1, 1'b1, 1'b0);
        add_fetches(5, 1'b0);
        wait_idle();

        // Directed, exact mode: a one-column run, then no run at all.
        write_exact_mode(1'b1);
        add_beat(KIND_RESIDUE, ASC_A, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_C | CASE_BIT, 1'b1, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_G, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_G | CASE_BIT, 1'b1, 1'b1, 1'b0);
        add_fetches(2, 1'b0);
        add_beat(KIND_RESIDUE, ASC_A, 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_C, 1'b1, 1'b1, 1'b0);
        add_fetches(1, 1'b0);
        wait_idle();

        // Random phases, alternating the window mode.
        for (p = 0; p < 6; p++) begin
            write_exact_mode(p % 2 == 1);
            add_random_phase(PHASE_BEATS, p == 2);
            wait_idle();
        end

        // Column deeper than the counters: the uncounted tail would flip the majority.
        write_exact_mode(1'b0);
        for (k = 0; k < 513; k++)
            add_beat(KIND_RESIDUE, residue_for(CODE_A), 1'b0, 1'b0, 1'b0);
        for (k = 0; k < 513; k++)
            add_beat(KIND_RESIDUE, residue_for(CODE_T), 1'b0, 1'b0, 1'b0);
        add_beat(KIND_RESIDUE, ASC_T, 1'b1, 1'b1, 1'b0);
        add_fetches(2, 1'b0);
        wait_idle();

        $display("Checked %0d consensus letters and %0d alignment summaries from %0d beats,",
                 letters_seen, summaries_seen, beats_in);
        $display("in both window modes, with a long result hold-off and an over-deep column.");
        if (fault_count == 0 && consensus_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results outstanding.", fault_count,
                     consensus_due.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
